>>> sv/d2r_pkg.sv
package d2r_pkg;

    // Field widths
    localparam int ValueW = 12;
    localparam int CharW  = 7;
    localparam int WeightW = 10;

    // Largest value that has a numeral
    localparam logic [ValueW-1:0] MaxValid = 12'd3999;

    // ASCII codes
    localparam logic [CharW-1:0] ChI  = 7'd73;
    localparam logic [CharW-1:0] ChV  = 7'd86;
    localparam logic [CharW-1:0] ChX  = 7'd88;
    localparam logic [CharW-1:0] ChL  = 7'd76;
    localparam logic [CharW-1:0] ChC  = 7'd67;
    localparam logic [CharW-1:0] ChD  = 7'd68;
    localparam logic [CharW-1:0] ChM  = 7'd77;
    localparam logic [CharW-1:0] ChNl = 7'd10;

    // Program: thirteen symbol steps, then the terminator step
    localparam int StepCount = 14;
    localparam int PcW = $clog2(StepCount);
    localparam logic [PcW-1:0] StepFirst = '0;
    localparam logic [PcW-1:0] StepEnd   = PcW'(StepCount - 1);

    typedef enum logic {
        OP_SYM,
        OP_END
    } op_t;

    // One control word of the sequencer program
    typedef struct packed {
        op_t                op;
        logic [WeightW-1:0] weight;
        logic [CharW-1:0]   ch_a;
        logic [CharW-1:0]   ch_b;
        logic               two;
    } ctrl_word_t;

    // One emitted character toward the output register
    typedef struct packed {
        logic             valid;
        logic [CharW-1:0] ch;
        logic             last;
        logic             err;
    } emit_t;

    function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
        ctrl_word_t w;
        w = '{OP_END, 10'd0, ChNl, ChNl, 1'b0};
        case (pc)
            4'd0:  w = '{OP_SYM, 10'd1000, ChM, ChM, 1'b0};
            4'd1:  w = '{OP_SYM, 10'd900,  ChC, ChM, 1'b1};
            4'd2:  w = '{OP_SYM, 10'd500,  ChD, ChD, 1'b0};
            4'd3:  w = '{OP_SYM, 10'd400,  ChC, ChD, 1'b1};
            4'd4:  w = '{OP_SYM, 10'd100,  ChC, ChC, 1'b0};
            4'd5:  w = '{OP_SYM, 10'd90,   ChX, ChC, 1'b1};
            4'd6:  w = '{OP_SYM, 10'd50,   ChL, ChL, 1'b0};
            4'd7:  w = '{OP_SYM, 10'd40,   ChX, ChL, 1'b1};
            4'd8:  w = '{OP_SYM, 10'd10,   ChX, ChX, 1'b0};
            4'd9:  w = '{OP_SYM, 10'd9,    ChI, ChX, 1'b1};
            4'd10: w = '{OP_SYM, 10'd5,    ChV, ChV, 1'b0};
            4'd11: w = '{OP_SYM, 10'd4,    ChI, ChV, 1'b1};
            4'd12: w = '{OP_SYM, 10'd1,    ChI, ChI, 1'b0};
            default: w = '{OP_END, 10'd0, ChNl, ChNl, 1'b0};
        endcase
        return w;
    endfunction

endpackage

>>> sv/d2r_seq.sv
module d2r_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic [d2r_pkg::ValueW-1:0]   in_value,
    output logic                         in_ready,
    input  logic                         out_free,
    output d2r_pkg::emit_t               emit
);

    logic                        busy_reg, busy_next;
    logic                        half_reg, half_next;
    logic                        err_reg, err_next;
    logic [d2r_pkg::PcW-1:0]     pc_reg, pc_next;
    logic [d2r_pkg::ValueW-1:0]  rem_reg, rem_next;
    d2r_pkg::ctrl_word_t         cw;
    logic [d2r_pkg::ValueW-1:0]  weight_ext;
    logic                        take;

    // Fetch the control word of the current step
    assign cw         = d2r_pkg::ucode_rom(pc_reg);
    assign weight_ext = {{(d2r_pkg::ValueW-d2r_pkg::WeightW){1'b0}}, cw.weight};
    assign in_ready   = !busy_reg;
    assign take       = in_valid && !busy_reg;

    // Accept a value, or execute one step: emit a letter, finish a pair, jump or terminate
    always_comb begin
        busy_next = busy_reg;
        half_next = half_reg;
        err_next  = err_reg;
        pc_next   = pc_reg;
        rem_next  = rem_reg;
        emit      = '{1'b0, d2r_pkg::ChNl, 1'b0, 1'b0};
        if (take) begin
            busy_next = 1'b1;
            half_next = 1'b0;
            rem_next  = in_value;
            err_next  = in_value > d2r_pkg::MaxValid;
            pc_next   = (in_value > d2r_pkg::MaxValid) ? d2r_pkg::StepEnd
                                                       : d2r_pkg::StepFirst;
        end else if (busy_reg) begin
            if (half_reg) begin
                if (out_free) begin
                    emit      = '{1'b1, cw.ch_b, 1'b0, 1'b0};
                    half_next = 1'b0;
                end
            end else begin
                unique case (cw.op)
                    d2r_pkg::OP_END: begin
                        if (out_free) begin
                            emit      = '{1'b1, d2r_pkg::ChNl, 1'b1, err_reg};
                            busy_next = 1'b0;
                        end
                    end
                    d2r_pkg::OP_SYM: begin
                        if (rem_reg >= weight_ext) begin
                            if (out_free) begin
                                emit      = '{1'b1, cw.ch_a, 1'b0, 1'b0};
                                rem_next  = rem_reg - weight_ext;
                                half_next = cw.two;
                            end
                        end else begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    default: pc_next = d2r_pkg::StepEnd;
                endcase
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            half_reg <= 1'b0;
            err_reg  <= 1'b0;
            pc_reg   <= d2r_pkg::StepFirst;
        end else begin
            busy_reg <= busy_next;
            half_reg <= half_next;
            err_reg  <= err_next;
            pc_reg   <= pc_next;
        end
    end

    // Remainder needs no reset
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

`ifndef ASSERT_OFF
    a_half_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (busy_reg && pc_reg != d2r_pkg::StepEnd))
        else $error("second letter pending outside a symbol step");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.valid && emit.last) |-> (pc_reg == d2r_pkg::StepEnd && !half_reg))
        else $error("terminator emitted before the end step");

    a_err_jumps: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && err_reg) |-> (pc_reg == d2r_pkg::StepEnd))
        else $error("out-of-range value walked the symbol steps");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.valid && emit.last) |=> !busy_reg)
        else $error("sequencer still busy after terminator");
`endif

endmodule

>>> sv/decimal_to_roman_encoder_core.sv
// Channel | Ports      | tdata (low bit up)        | tuser | tlast
// input   | s_t*       | value[11:0], 4 zero bits  | -     | -
// result  | m_t*       | character[6:0], one zero  | error | last
//
// Between one accept and the earliest next, the sequencer takes the accept, emits
// each letter, steps past each symbol step that stops matching, and emits the
// terminator; an out-of-range value jumps straight to the terminator. The microcode
// step counter and the single output word register set this pace.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// A stall on m_tready holds the sequencer at its next letter or terminator.
module decimal_to_roman_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[11:0], zeros[15:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[6:0], zero[7]
    output logic        m_tlast,
    output logic        m_tuser    // error
);

    d2r_pkg::emit_t               emit;
    logic                         out_free;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [d2r_pkg::CharW-1:0]    char_reg;
    logic                         last_reg;
    logic                         err_reg;

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    d2r_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_value (s_tdata[d2r_pkg::ValueW-1:0]),
        .in_ready (s_tready),
        .out_free (out_free),
        .emit     (emit)
    );

    // Advance output valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit.valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the output word
    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            char_reg <= emit.ch;
            last_reg <= emit.last;
            err_reg  <= emit.err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

`ifndef ASSERT_OFF
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error flag on a word that is not the terminator");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while converting");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> out_free)
        else $error("output word overwritten before it was taken");
`endif

endmodule

>>> test/decimal_to_roman_encoder_core_tb.sv
import d2r_pkg::*;

// One expected character word on the result channel
typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             err;
} numeral_char_t;

class roman_scoreboard;
    numeral_char_t due_q[$];
    int            mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Spell out one value by greedy subtraction and queue its characters
    function void note_value(input logic [ValueW-1:0] value);
        int unsigned      weights [13];
        logic [CharW-1:0] lead    [13];
        logic [CharW-1:0] trail   [13];
        int unsigned      rem;
        int               k;
        numeral_char_t    c;
        weights = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
        lead    = '{ChM, ChC, ChD, ChC, ChC, ChX, ChL, ChX, ChX, ChI, ChV, ChI, ChI};
        trail   = '{'0, ChM, '0, ChD, '0, ChC, '0, ChL, '0, ChX, '0, ChV, '0};
        rem = value;
        k = 0;
        // Out-of-range value: bare terminator with the error flag
        if (value > MaxValid) begin
            c = '{ChNl, 1'b1, 1'b1};
            due_q.push_back(c);
            return;
        end
        for (int i = 0; i < 13; i++) begin
            while (rem >= weights[i] && k < 15) begin
                rem -= weights[i];
                c = '{lead[i], 1'b0, 1'b0};
                due_q.push_back(c);
                k++;
                if (trail[i] != '0 && k < 15) begin
                    c = '{trail[i], 1'b0, 1'b0};
                    due_q.push_back(c);
                    k++;
                end
            end
        end
        c = '{ChNl, 1'b1, 1'b0};
        due_q.push_back(c);
    endfunction

    // Compare one received character word against the oldest expectation
    function void check_char(input logic [CharW-1:0] ch, input logic last,
                             input logic err);
        numeral_char_t want;
        if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: ch=%0d last=%0b err=%0b", ch, last, err);
            return;
        end
        want = due_q.pop_front();
        if (want.ch !== ch || want.last !== last || want.err !== err) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: ch exp %0d got %0d, last exp %0b got %0b, err exp %0b got %0b",
                         want.ch, ch, want.last, last, want.err, err);
        end
    endfunction

    function int pending();
        return due_q.size();
    endfunction
endclass

module decimal_to_roman_encoder_core_tb;
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // value[11:0], zeros[15:12]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // character[6:0], zero[7]
    logic        m_tlast;
    logic        m_tuser;           // error

    roman_scoreboard sb = new();

    // Steady stretch: neither side idles
    logic calm = 1'b0;
    int   chars_seen = 0;
    int   sink_hold  = 0;
    bit   hold_done  = 1'b0;

    logic [ValueW-1:0] corner_values [25] = '{
        12'd0, 12'd1, 12'd4, 12'd9, 12'd10, 12'd40, 12'd49, 12'd50, 12'd90,
        12'd99, 12'd100, 12'd300, 12'd400, 12'd444, 12'd500, 12'd900, 12'd999,
        12'd1000, 12'd1994, 12'd2047, 12'd2048, 12'd3888, 12'd3999, 12'd4000,
        12'd4095
    };

    decimal_to_roman_encoder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Drive result-side ready; one long hold-off after the first few hundred words
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                chars_seen <= chars_seen + 1;
            if (sink_hold > 0) begin
                m_tready  <= 1'b0;
                sink_hold <= sink_hold - 1;
            end else if (!hold_done && chars_seen >= 400) begin
                m_tready  <= 1'b0;
                sink_hold <= 250;
                hold_done <= 1'b1;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_char(m_tdata[CharW-1:0], m_tlast, m_tuser);
    end

    // Offer one value, idling at random first, and hold until it is taken
    task automatic send_value(input logic [ValueW-1:0] value);
        while (!calm && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, value};
        do @(posedge aclk); while (!s_tready);
        sb.note_value(value);
    endtask

    // Random value, weighted toward long numerals and with some out of range
    function automatic logic [ValueW-1:0] pick_value();
        int unsigned      sel;
        int unsigned      heavy [3];
        logic [ValueW-1:0] v;
        heavy = '{3, 7, 8};
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            v = ValueW'($urandom_range(4000, 4095));
        end else if (sel <= 2) begin
            v = ValueW'($urandom_range(0, 3) * 1000 + heavy[$urandom_range(0, 2)] * 100
                        + heavy[$urandom_range(0, 2)] * 10 + heavy[$urandom_range(0, 2)]);
        end else if (sel == 3) begin
            v = ValueW'($urandom_range(0, 4095));
        end else begin
            v = ValueW'($urandom_range(0, 3999));
        end
        return v;
    endfunction

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners
        foreach (corner_values[i])
            send_value(corner_values[i]);

        // Random values, with a steady stretch and one full drain
        for (int n = 0; n < 280; n++) begin
            if (n == 120)
                calm <= 1'b1;
            if (n == 170)
                calm <= 1'b0;
            if (n == 220) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0)
                    @(posedge aclk);
            end
            send_value(pick_value());
        end
        s_tvalid <= 1'b0;

        // Drain outstanding words, then let the sequencer settle
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
